// ===== rtl/core/pnlt_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pnlt_pkg
// Shared types, register indexes and a helper of the per-node I/O limit table.
// ----------------------------------------------------------------------------
package pnlt_pkg;

  localparam int unsigned CFG_IDX_W = 3;

  localparam logic [CFG_IDX_W-1:0] CFG_ENABLED  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_CAP      = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_GRANULE  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_LEGACY   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_FALLBACK = 3'd4;

  localparam logic KIND_PROBE  = 1'b0;
  localparam logic KIND_LOOKUP = 1'b1;

  localparam logic [31:0] CAP_RESET      = 32'd1048576;
  localparam logic [4:0]  GRANULE_RESET  = 5'd12;
  localparam logic [31:0] LEGACY_RESET   = 32'd1048576;
  localparam logic [31:0] FALLBACK_RESET = 32'd65536;

  typedef struct packed {
    logic        verified;
    logic        usable;
    logic [31:0] rd_limit;
    logic [31:0] wr_limit;
    logic [31:0] gen;
  } entry_t;

  typedef struct packed {
    logic   seen;
    entry_t entry;
  } rd_port_t;

  // Cap a raw limit and round it down to the granule.
  function automatic logic [31:0] cap_round(input logic [31:0] raw,
                                            input logic [31:0] cap,
                                            input logic [4:0]  shift);
    logic [31:0] capped;
    capped = (raw > cap) ? cap : raw;
    return capped & (32'hFFFF_FFFF << shift);
  endfunction

endpackage
`default_nettype wire

// ===== rtl/core/pnlt_if.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pnlt_if
// Request, response and configuration channels of the limit table.
// ----------------------------------------------------------------------------
interface pnlt_req_if;
  logic        valid;
  logic        ready;
  logic        kind;
  logic [7:0]  node_id;
  logic        probe_good;
  logic [31:0] raw_read;
  logic [31:0] raw_write;

  modport source (output valid, kind, node_id, probe_good, raw_read, raw_write,
                  input ready);
  modport sink (input valid, kind, node_id, probe_good, raw_read, raw_write,
                output ready);
endinterface

interface pnlt_rsp_if;
  logic        valid;
  logic        ready;
  logic        recall;
  logic [31:0] entry_read;
  logic [31:0] entry_write;
  logic [31:0] entry_gen;
  logic        entry_eligible;
  logic [31:0] min_read;
  logic [31:0] min_write;

  modport source (output valid, recall, entry_read, entry_write, entry_gen,
                  entry_eligible, min_read, min_write, input ready);
  modport sink (input valid, recall, entry_read, entry_write, entry_gen,
                entry_eligible, min_read, min_write, output ready);
endinterface

interface pnlt_cfg_if;
  logic        valid;
  logic        ready;
  logic [2:0]  index;
  logic [31:0] data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface
`default_nettype wire

// ===== rtl/core/pnlt_store.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pnlt_store
// Entry memory with one registered read port and one write port; seen bits
// in flip-flops cleared by reset mark which entries hold data.
// ----------------------------------------------------------------------------
module pnlt_store
  import pnlt_pkg::*;
#(
  parameter int unsigned DEPTH = 64,
  parameter int unsigned AW    = 6
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic [AW-1:0] rd_addr,
  output rd_port_t           rd_q,
  input  wire logic          wr_en,
  input  wire logic [AW-1:0] wr_addr,
  input  wire entry_t        wr_data
);

  entry_t           mem [DEPTH];
  logic [DEPTH-1:0] seen;
  entry_t           rd_entry;
  logic             rd_seen;

  assign rd_q = '{seen: rd_seen, entry: rd_entry};

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_entry <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      seen    <= '0;
      rd_seen <= 1'b0;
    end else begin
      rd_seen <= seen[rd_addr];
      if (wr_en) begin
        seen[wr_addr] <= 1'b1;
      end
    end
  end

endmodule
`default_nettype wire

// ===== rtl/core/per_node_io_limit_table_top.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// per_node_io_limit_table_top
// Per-node read/write limit table: probe reports update entries, lookups
// read them, and every change rescans the minima over eligible entries.
//
//   channel  dir  payload                                        accepted when
//   req      in   kind, node_id, probe_good, raw_read, raw_write valid && ready
//   rsp      out  recall, entry_*, min_read, min_write           valid && ready
//   cfg      in   index, data                                    valid && ready
//
// A request that changes an entry is answered after evaluate, a rescan over
// every entry at one read per cycle, settling the minima and the load; the
// next request is taken once the sequencer is back in idle. Any other request
// goes from evaluate straight to the load. A response still waiting in the
// output register holds the last step. Reset clears the seen bits, the state
// and rsp.valid, and sets the config and least registers to their reset values.
// cfg is always ready.
module per_node_io_limit_table_top
  import pnlt_pkg::*;
#(
  parameter int unsigned TABLE_SIZE = 64
) (
  input wire logic   clk,
  input wire logic   rst,
  pnlt_req_if.sink   req,
  pnlt_rsp_if.source rsp,
  pnlt_cfg_if.sink   cfg
);

  localparam int unsigned AW = (TABLE_SIZE > 1) ? $clog2(TABLE_SIZE) : 1;
  localparam int unsigned CW = $clog2(TABLE_SIZE + 1);

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_EVAL  = 3'd1;
  localparam logic [2:0] ST_SCAN  = 3'd2;
  localparam logic [2:0] ST_LEAST = 3'd3;
  localparam logic [2:0] ST_DONE  = 3'd4;

  logic [2:0] state;

  logic        enabled;
  logic [31:0] cap_bytes;
  logic [4:0]  granule_shift;
  logic [31:0] legacy_bytes;
  logic [31:0] fallback_bytes;

  logic        item_kind;
  logic [7:0]  item_id;
  logic        item_ok;
  logic        item_in_range;
  logic [31:0] eff_rd;
  logic [31:0] eff_wr;

  logic [31:0] least_read;
  logic [31:0] least_write;

  logic          res_recall;
  entry_t        res_entry;

  logic [CW-1:0] scan_cnt;
  logic          scan_pend;
  logic          acc_any;
  logic [31:0]   acc_rd;
  logic [31:0]   acc_wr;

  rd_port_t      rd_q;
  logic [AW-1:0] rd_addr;
  logic          wr_en;

  entry_t cur;
  entry_t nxt;
  logic   changed;
  logic   recall_next;
  logic   active;
  logic   shown;
  logic   rsp_load;

  // Configuration registers.
  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      enabled        <= 1'b0;
      cap_bytes      <= CAP_RESET;
      granule_shift  <= GRANULE_RESET;
      legacy_bytes   <= LEGACY_RESET;
      fallback_bytes <= FALLBACK_RESET;
    end else if (cfg.valid) begin
      case (cfg.index)
        CFG_ENABLED:  enabled        <= cfg.data[0];
        CFG_CAP:      cap_bytes      <= cfg.data;
        CFG_GRANULE:  granule_shift  <= cfg.data[4:0];
        CFG_LEGACY:   legacy_bytes   <= cfg.data;
        CFG_FALLBACK: fallback_bytes <= cfg.data;
        default: ;
      endcase
    end
  end

  assign req.ready = (state == ST_IDLE);

  // Latch the request and its capped, rounded limits.
  always_ff @(posedge clk) begin
    if (req.valid && req.ready) begin
      item_kind     <= req.kind;
      item_id       <= req.node_id;
      item_ok       <= req.probe_good;
      item_in_range <= ({1'b0, req.node_id} < 9'(TABLE_SIZE));
      eff_rd        <= cap_round(req.raw_read, cap_bytes, granule_shift);
      eff_wr        <= cap_round(req.raw_write, cap_bytes, granule_shift);
    end
  end

  assign rd_addr = (state == ST_SCAN) ? scan_cnt[AW-1:0] : req.node_id[AW-1:0];

  pnlt_store #(
    .DEPTH (TABLE_SIZE),
    .AW    (AW)
  ) u_store (
    .clk     (clk),
    .rst     (rst),
    .rd_addr (rd_addr),
    .rd_q    (rd_q),
    .wr_en   (wr_en),
    .wr_addr (item_id[AW-1:0]),
    .wr_data (nxt)
  );

  // Entry update for a probe.
  assign active = enabled && item_in_range && (item_kind == KIND_PROBE);
  assign shown  = enabled && item_in_range;

  always_comb begin
    if (rd_q.seen) begin
      cur = rd_q.entry;
    end else begin
      cur = '{verified: 1'b0, usable: 1'b1, rd_limit: fallback_bytes,
              wr_limit: fallback_bytes, gen: 32'd0};
    end
    nxt         = cur;
    changed     = !rd_q.seen;
    recall_next = 1'b0;
    if ((item_kind == KIND_PROBE) && item_ok) begin
      if ((eff_rd == 32'd0) || (eff_wr == 32'd0)) begin
        if (cur.usable) begin
          nxt.usable  = 1'b0;
          nxt.gen     = cur.gen + 32'd1;
          changed     = 1'b1;
          recall_next = 1'b1;
        end
      end else if (!(cur.verified && cur.usable && (eff_rd == cur.rd_limit) &&
                     (eff_wr == cur.wr_limit))) begin
        nxt.verified = 1'b1;
        nxt.usable   = 1'b1;
        nxt.rd_limit = eff_rd;
        nxt.wr_limit = eff_wr;
        nxt.gen      = cur.gen + 32'd1;
        changed      = 1'b1;
        recall_next  = cur.verified &&
                       ((eff_rd < cur.rd_limit) || (eff_wr < cur.wr_limit));
      end
    end
  end

  assign wr_en    = (state == ST_EVAL) && active && changed;
  assign rsp_load = (state == ST_DONE) && (!rsp.valid || rsp.ready);

  // Sequencer.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      scan_pend <= 1'b0;
    end else begin
      scan_pend <= 1'b0;
      case (state)
        ST_IDLE: begin
          if (req.valid) begin
            state <= ST_EVAL;
          end
        end
        ST_EVAL: begin
          state <= wr_en ? ST_SCAN : ST_DONE;
        end
        ST_SCAN: begin
          if (scan_cnt == CW'(TABLE_SIZE)) begin
            state <= ST_LEAST;
          end else begin
            scan_pend <= 1'b1;
          end
        end
        ST_LEAST: begin
          state <= ST_DONE;
        end
        ST_DONE: begin
          if (rsp_load) begin
            state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  // Hold the step's entry view.
  always_ff @(posedge clk) begin
    if (state == ST_EVAL) begin
      res_recall <= active && recall_next;
      if (shown) begin
        res_entry <= nxt;
      end else begin
        res_entry <= '{verified: 1'b0, usable: 1'b1, rd_limit: legacy_bytes,
                       wr_limit: legacy_bytes, gen: 32'd0};
      end
    end
  end

  // Rescan over seen and usable entries.
  always_ff @(posedge clk) begin
    if (state == ST_EVAL) begin
      scan_cnt <= '0;
      acc_any  <= 1'b0;
    end else begin
      if ((state == ST_SCAN) && (scan_cnt != CW'(TABLE_SIZE))) begin
        scan_cnt <= scan_cnt + CW'(1);
      end
      if (scan_pend && rd_q.seen && rd_q.entry.usable) begin
        acc_any <= 1'b1;
        if (!acc_any || (rd_q.entry.rd_limit < acc_rd)) begin
          acc_rd <= rd_q.entry.rd_limit;
        end
        if (!acc_any || (rd_q.entry.wr_limit < acc_wr)) begin
          acc_wr <= rd_q.entry.wr_limit;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      least_read  <= LEGACY_RESET;
      least_write <= LEGACY_RESET;
    end else if (state == ST_LEAST) begin
      least_read  <= acc_any ? acc_rd : legacy_bytes;
      least_write <= acc_any ? acc_wr : legacy_bytes;
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp.valid <= 1'b0;
    end else if (rsp_load) begin
      rsp.valid <= 1'b1;
    end else if (rsp.ready) begin
      rsp.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rsp_load) begin
      rsp.recall         <= res_recall;
      rsp.entry_read     <= res_entry.rd_limit;
      rsp.entry_write    <= res_entry.wr_limit;
      rsp.entry_gen      <= res_entry.gen;
      rsp.entry_eligible <= res_entry.usable;
      rsp.min_read       <= enabled ? least_read : legacy_bytes;
      rsp.min_write      <= enabled ? least_write : legacy_bytes;
    end
  end

  // Checks.
  a_write_in_eval: assert property (@(posedge clk) disable iff (rst)
    wr_en |-> (state == ST_EVAL) && enabled && item_in_range)
    else $error("entry write outside evaluation");

  a_accept_to_eval: assert property (@(posedge clk) disable iff (rst)
    (req.valid && req.ready) |=> (state == ST_EVAL))
    else $error("accepted request not evaluated");

  a_scan_bound: assert property (@(posedge clk) disable iff (rst)
    (state == ST_SCAN) |-> (scan_cnt <= CW'(TABLE_SIZE)))
    else $error("rescan counter past table");

  a_least_only_after_scan: assert property (@(posedge clk) disable iff (rst)
    (!$past(rst) && (!$stable(least_read) || !$stable(least_write)))
      |-> ($past(state) == ST_LEAST))
    else $error("minima changed outside rescan");

endmodule
`default_nettype wire
